>>> hw/rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

    localparam int PLE_DEPTH_DEF = 64;
    localparam int POS_W         = 7;
    localparam int WORD_W        = 32;
    localparam int COUNT_W       = 7;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_READ   = 3'd4,
        OP_FRONT  = 3'd5,
        OP_BACK   = 3'd6,
        OP_CLEAR  = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what one cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } req_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
    } rsp_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/ple_req_if.sv
`default_nettype none

interface ple_req_if import ple_pkg::*; ();
    logic      valid;
    logic      ready;
    req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ple_rsp_if.sv
`default_nettype none

interface ple_rsp_if import ple_pkg::*; ();
    logic      valid;
    logic      ready;
    rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ple_cell.sv
`default_nettype none

module ple_cell import ple_pkg::*; #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  wire logic                     clk,
    input  wire cell_op_t                 op,
    input  wire logic [IDX_W-1:0]         sel_idx,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire logic signed [WORD_W-1:0] prev_data,
    input  wire logic signed [WORD_W-1:0] next_data,
    output logic signed [WORD_W-1:0]      data,
    output logic signed [WORD_W-1:0]      rd_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     hit;
    logic                     above;

    assign hit   = (sel_idx == MY_IDX);
    assign above = (MY_IDX > sel_idx);

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            CELL_WRITE:
            begin
                if (hit)
                    data_next = value;
            end
            CELL_INSERT:
            begin
                if (hit)
                    data_next = value;
                else if (above)
                    data_next = prev_data;   // shift up
            end
            CELL_ERASE:
            begin
                if (hit || above)
                    data_next = next_data;   // shift down
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
// Results: the result of each accepted item is registered in the output register.
// Throughput: one item per cycle unless a response waits there without rsp.ready;
// each push, insert or erase loads or shifts the cells at and above its position together.
// Reset: rst_n is asynchronous, active low; it empties the list and clears the output
// valid flag. The word cells hold no reset and are only read below the count.
`default_nettype none

module positional_list_engine import ple_pkg::*; #(
    parameter int DEPTH = PLE_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ple_req_if.sink    req,
    ple_rsp_if.source  rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // compare width: wide enough for both the position field and the count
    localparam int CMPW  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // list state
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // output register
    logic      out_valid_reg;
    rsp_item_t out_item_reg;
    rsp_item_t out_item_next;

    logic accept;

    // shared per-item control
    cell_op_t         cell_op;
    logic [IDX_W-1:0] sel_idx;
    logic             rd_ok;
    status_t          status;

    logic [CMPW-1:0]  pos_ext;
    logic [CMPW-1:0]  cnt_ext;
    logic [CMPW-1:0]  cnt_m1_ext;
    logic [CMPW-1:0]  cnt_new_ext;
    logic [CNT_W-1:0] cnt_m1;
    logic             full;
    logic             empty;

    // cell row
    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] cell_rd   [DEPTH];
    logic signed [WORD_W-1:0] rd_or;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_ext     = CMPW'(req.payload.position);
    assign cnt_ext     = CMPW'(cnt_reg);
    assign cnt_m1      = cnt_reg - 1'b1;
    assign cnt_m1_ext  = CMPW'(cnt_m1);
    assign cnt_new_ext = CMPW'(cnt_next);
    assign full        = (cnt_reg == FULL_CNT);
    assign empty       = (cnt_reg == '0);

    // Decode: status, count update, cell command and the one index the row uses.
    always_comb
    begin
        cell_op  = CELL_HOLD;
        sel_idx  = pos_ext[IDX_W-1:0];
        rd_ok    = 1'b0;
        status   = ST_OK;
        cnt_next = cnt_reg;
        unique case (req.payload.opcode)
            OP_PUSH:
            begin
                sel_idx = cnt_ext[IDX_W-1:0];
                if (full)
                    status = ST_FULL;
                else
                begin
                    cell_op  = CELL_WRITE;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (empty)
                    status = ST_RANGE;
                else
                    cnt_next = cnt_m1;
            end
            OP_INSERT:
            begin
                // range check comes before the full check
                if (pos_ext > cnt_ext)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    cell_op  = CELL_INSERT;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_ERASE:
            begin
                if (pos_ext >= cnt_ext)
                    status = ST_RANGE;
                else
                begin
                    cell_op  = CELL_ERASE;
                    cnt_next = cnt_m1;
                end
            end
            OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                    status = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            OP_FRONT:
            begin
                sel_idx = '0;
                if (empty)
                    status = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            OP_BACK:
            begin
                sel_idx = cnt_m1_ext[IDX_W-1:0];
                if (empty)
                    status = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Row of cells: on insert a cell takes its lower neighbor, on erase its upper.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] prev_d;
        logic signed [WORD_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = cell_data[i];
        end
        else
        begin : g_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[i];
        end
        else
        begin : g_next
            assign next_d = cell_data[i+1];
        end

        ple_cell #(
            .IDX   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk       (clk),
            .op        (accept ? cell_op : CELL_HOLD),
            .sel_idx   (sel_idx),
            .value     (req.payload.value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .rd_data   (cell_rd[i])
        );
    end

    // Only the selected cell drives nonzero read data.
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++)
            rd_or = rd_or | cell_rd[k];
    end

    always_comb
    begin
        out_item_next.read_value = rd_ok ? rd_or : '0;
        out_item_next.status     = status;
        out_item_next.count      = cnt_new_ext[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                cnt_reg <= cnt_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_item_reg <= out_item_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

`ifndef SYNTHESIS
    // count never passes the capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above capacity");

    // a full report means the list really is full
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.status == ST_FULL) |-> cnt_reg == FULL_CNT)
        else $error("full status with list not full");

    // failed operations return no data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.status != ST_OK) |-> rsp.payload.read_value == '0)
        else $error("nonzero read data on error");

    // clear empties the list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.payload.opcode == OP_CLEAR) |=> cnt_reg == '0)
        else $error("clear left entries");
`endif

endmodule

`default_nettype wire
